FILE: hw/rtl/rotated_ellipse_mask_generator_defines.svh
// Assertion macros shared by the rotated ellipse mask generator RTL.
`ifndef ROTATED_ELLIPSE_MASK_GENERATOR_DEFINES_SVH
`define ROTATED_ELLIPSE_MASK_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define REMG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define REMG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/remg_pkg.sv
// Types, constants and the Q1.14 sine table of the rotated ellipse mask generator.
`default_nettype none

package remg_pkg;

  localparam int MAX_RADIUS_DEF = 31;

  localparam int RADIUS_W   = 5;
  localparam int DEG_W      = 9;
  localparam int INDEX_W    = 6;
  localparam int ROW_BITS_W = 63;
  localparam int SIN_W      = 16;
  localparam int RSQ_W      = 2 * RADIUS_W;
  localparam int SQ_W       = 30;
  localparam int ACC_W      = 56;
  localparam int MA_W       = 44;
  localparam int MB_W       = 17;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int RHS_SHIFT  = 28;

  localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_EMIT
  } state_t;

  // Setup program: each step is one multiply followed by one write-back.
  typedef enum logic [3:0] {
    STEP_A2,
    STEP_B2,
    STEP_CC,
    STEP_SS,
    STEP_CS,
    STEP_A_LO,
    STEP_A_HI,
    STEP_C_LO,
    STEP_C_HI,
    STEP_B,
    STEP_RHS,
    STEP_AXIS2,
    STEP_DX0,
    STEP_DY0,
    STEP_LHS0
  } step_t;

  localparam logic [14:0] QUARTER_SINE [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // Sine of deg degrees in Q1.14; deg must lie in 0..359.
  function automatic logic signed [SIN_W-1:0] sine_q14(input logic [DEG_W-1:0] deg);
    logic [DEG_W-1:0]        k;
    logic                    neg;
    logic signed [SIN_W-1:0] mag;
    if (deg <= 9'd90) begin
      k   = deg;
      neg = 1'b0;
    end else if (deg <= 9'd180) begin
      k   = 9'd180 - deg;
      neg = 1'b0;
    end else if (deg <= 9'd270) begin
      k   = deg - 9'd180;
      neg = 1'b1;
    end else begin
      k   = DEG_FULL - deg;
      neg = 1'b1;
    end
    mag = {1'b0, QUARTER_SINE[k[6:0]]};
    return neg ? -mag : mag;
  endfunction

  // Cosine of deg degrees in Q1.14, taken as the sine of deg + 90.
  function automatic logic signed [SIN_W-1:0] cosine_q14(input logic [DEG_W-1:0] deg);
    logic [DEG_W:0] d;
    d = {1'b0, deg} + 10'd90;
    if (d >= {1'b0, DEG_FULL}) begin
      d = d - {1'b0, DEG_FULL};
    end
    return sine_q14(d[DEG_W-1:0]);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rotated_ellipse_mask_generator.sv
// Rotated ellipse morphology mask generator: one request in, one mask row per result out.
//
// Input channel (in_*): a request carries two radii and a rotation in degrees.
// Angles 360..511 are taken modulo 360 and radii above MAX_RADIUS saturate.
// Output channel (out_*): one result per mask row, top row first, with
// out_last_row set on row 2*axis, axis being the larger radius.
// A request is taken when in_valid is high and in_stall is low; in_stall
// stays high from then until the last row has been loaded into the output
// register, so one request is in work at a time.
// Setup: one shared 44x17 multiplier computes the quadratic-form coefficients,
// each step a multiply followed by a write-back; then each row is walked at one
// pixel per cycle by forward differencing on the lhs_r accumulator, and the row
// is then handed over to the output register.
// When the receiver stalls, the finished row waits in the output register and
// the sequencer holds before the next row until the register is free.
// Synchronous reset (rst_n low) returns to idle and drops out_valid.
`default_nettype none

`include "rotated_ellipse_mask_generator_defines.svh"

module rotated_ellipse_mask_generator #(
  parameter int MAX_RADIUS = remg_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [remg_pkg::RADIUS_W-1:0]   in_x_radius,
  input  wire logic [remg_pkg::RADIUS_W-1:0]   in_y_radius,
  input  wire logic [remg_pkg::DEG_W-1:0]      in_rotation_deg,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [remg_pkg::INDEX_W-1:0]         out_row_index,
  output logic [remg_pkg::ROW_BITS_W-1:0]      out_row_bits,
  output logic                                 out_last_row
);

  import remg_pkg::*;

  localparam int ROW_W = 2 * MAX_RADIUS + 1;
  localparam int IDX_W = $clog2(ROW_W);

  localparam logic [RADIUS_W-1:0] RADIUS_CAP = RADIUS_W'(MAX_RADIUS);

  // Control state.
  state_t state_r, state_nxt;
  step_t  step_r;
  logic   phase_r;
  logic   out_valid_r, out_valid_nxt;

  // Request operands.
  logic [RADIUS_W-1:0]     rx_r, ry_r, axis_r;
  logic [DEG_W-1:0]        deg_r;
  logic                    empty_r;
  logic signed [SIN_W-1:0] s_r, c_r;

  // Shared multiplier.
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  prod_lo;

  // Coefficients of lhs(x,y) = A*x^2 + B*x*y + C*y^2.
  logic [RSQ_W-1:0]         a2_r, b2_r, axis2_r;
  logic signed [SQ_W-1:0]   cc_r, ss_r, cs_r;
  logic signed [ACC_W-1:0]  coef_a_r, coef_b_r, coef_c_r, rhs_r;
  logic signed [MA_W-1:0]   sum_r;
  logic signed [RSQ_W:0]    b2_minus_a2;
  logic signed [ACC_W-1:0]  two_a, two_c;

  // Forward-difference walk.
  logic signed [ACC_W-1:0]  lhs_r, dx_r, lhs_row_r, dxrow_r, dy_r;
  logic [ROW_W-1:0]         row_r;
  logic [INDEX_W-1:0]       xcnt_r, ycnt_r;
  logic [INDEX_W-1:0]       two_axis;
  logic                     pix_in;

  // Output register.
  logic [INDEX_W-1:0]       out_row_index_r;
  logic [ROW_BITS_W-1:0]    out_row_bits_r;
  logic                     out_last_row_r;

  logic accept_in;
  logic emit_load;
  logic row_last;
  logic setup_done;

  assign two_axis    = {axis_r, 1'b0};
  assign prod_lo     = prod_r[ACC_W-1:0];
  assign two_a       = coef_a_r <<< 1;
  assign two_c       = coef_c_r <<< 1;
  assign b2_minus_a2 = $signed({1'b0, b2_r}) - $signed({1'b0, a2_r});
  assign pix_in      = !empty_r && (lhs_r <= rhs_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (setup_done) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (xcnt_r == two_axis) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) state_nxt = row_last ? ST_IDLE : ST_WALK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    accept_in     = in_valid && (state_r == ST_IDLE);
    setup_done    = (state_r == ST_SETUP) && phase_r && (step_r == STEP_LHS0);
    row_last      = (ycnt_r == two_axis);
    emit_load     = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
    out_valid_nxt = emit_load || (out_valid_r && out_stall);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      STEP_A2: begin
        mul_a = MA_W'(rx_r);
        mul_b = MB_W'(rx_r);
      end
      STEP_B2: begin
        mul_a = MA_W'(ry_r);
        mul_b = MB_W'(ry_r);
      end
      STEP_CC: begin
        mul_a = MA_W'(c_r);
        mul_b = MB_W'(c_r);
      end
      STEP_SS: begin
        mul_a = MA_W'(s_r);
        mul_b = MB_W'(s_r);
      end
      STEP_CS: begin
        mul_a = MA_W'(c_r);
        mul_b = MB_W'(s_r);
      end
      STEP_A_LO: begin
        mul_a = MA_W'(cc_r);
        mul_b = MB_W'(b2_r);
      end
      STEP_A_HI: begin
        mul_a = MA_W'(ss_r);
        mul_b = MB_W'(a2_r);
      end
      STEP_C_LO: begin
        mul_a = MA_W'(ss_r);
        mul_b = MB_W'(b2_r);
      end
      STEP_C_HI: begin
        mul_a = MA_W'(cc_r);
        mul_b = MB_W'(a2_r);
      end
      STEP_B: begin
        mul_a = MA_W'(cs_r);
        mul_b = MB_W'(b2_minus_a2);
      end
      STEP_RHS: begin
        mul_a = MA_W'(a2_r);
        mul_b = MB_W'(b2_r);
      end
      STEP_AXIS2: begin
        mul_a = MA_W'(axis_r);
        mul_b = MB_W'(axis_r);
      end
      STEP_DX0, STEP_DY0: begin
        mul_a = sum_r;
        mul_b = MB_W'(axis_r);
      end
      STEP_LHS0: begin
        mul_a = sum_r;
        mul_b = MB_W'(axis2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_A2;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept_in) begin
        step_r  <= STEP_A2;
        phase_r <= 1'b0;
      end else if (state_r == ST_SETUP) begin
        phase_r <= !phase_r;
        if (phase_r && !setup_done) step_r <= step_t'(step_r + 4'd1);
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      rx_r    <= (in_x_radius > RADIUS_CAP) ? RADIUS_CAP : in_x_radius;
      ry_r    <= (in_y_radius > RADIUS_CAP) ? RADIUS_CAP : in_y_radius;
      axis_r  <= (in_x_radius > in_y_radius) ?
                 ((in_x_radius > RADIUS_CAP) ? RADIUS_CAP : in_x_radius) :
                 ((in_y_radius > RADIUS_CAP) ? RADIUS_CAP : in_y_radius);
      empty_r <= (in_x_radius == '0) || (in_y_radius == '0);
      deg_r   <= (in_rotation_deg >= DEG_FULL) ? in_rotation_deg - DEG_FULL
                                               : in_rotation_deg;
    end

    if (state_r == ST_SETUP && !phase_r) begin
      prod_r <= mul_a * mul_b;
      // The rotation is negated: sin(-t) = -sin(t), cos(-t) = cos(t).
      if (step_r == STEP_A2) begin
        s_r <= -sine_q14(deg_r);
        c_r <= cosine_q14(deg_r);
      end
    end

    if (state_r == ST_SETUP && phase_r) begin
      unique case (step_r)
        STEP_A2:   a2_r     <= prod_r[RSQ_W-1:0];
        STEP_B2:   b2_r     <= prod_r[RSQ_W-1:0];
        STEP_CC:   cc_r     <= prod_r[SQ_W-1:0];
        STEP_SS:   ss_r     <= prod_r[SQ_W-1:0];
        STEP_CS:   cs_r     <= prod_r[SQ_W-1:0];
        STEP_A_LO: coef_a_r <= prod_lo;
        STEP_A_HI: coef_a_r <= coef_a_r + prod_lo;
        STEP_C_LO: coef_c_r <= prod_lo;
        STEP_C_HI: coef_c_r <= coef_c_r + prod_lo;
        STEP_B:    coef_b_r <= prod_lo <<< 1;
        STEP_RHS:  rhs_r    <= prod_lo <<< RHS_SHIFT;
        STEP_AXIS2: begin
          axis2_r <= prod_r[RSQ_W-1:0];
          sum_r   <= MA_W'(two_a + coef_b_r);
        end
        STEP_DX0: begin
          // Step in x at the left edge of the top row: A*(1-2*axis) - B*axis.
          dxrow_r <= coef_a_r - prod_lo;
          sum_r   <= MA_W'(two_c + coef_b_r);
        end
        STEP_DY0: begin
          dy_r  <= coef_c_r - prod_lo;
          sum_r <= MA_W'(coef_a_r + coef_b_r + coef_c_r);
        end
        STEP_LHS0: begin
          lhs_row_r <= prod_lo;
          lhs_r     <= prod_lo;
          dx_r      <= dxrow_r;
          row_r     <= '0;
          xcnt_r    <= '0;
          ycnt_r    <= '0;
        end
        default: ;
      endcase
    end

    if (state_r == ST_WALK) begin
      row_r[xcnt_r[IDX_W-1:0]] <= pix_in;
      lhs_r  <= lhs_r + dx_r;
      dx_r   <= dx_r + two_a;
      xcnt_r <= xcnt_r + 1'b1;
    end

    if (emit_load) begin
      out_row_index_r <= ycnt_r;
      out_row_bits_r  <= ROW_BITS_W'(row_r);
      out_last_row_r  <= row_last;
      // Move the row-start values down one row.
      lhs_row_r <= lhs_row_r + dy_r;
      lhs_r     <= lhs_row_r + dy_r;
      dy_r      <= dy_r + two_c;
      dxrow_r   <= dxrow_r + coef_b_r;
      dx_r      <= dxrow_r + coef_b_r;
      row_r     <= '0;
      xcnt_r    <= '0;
      ycnt_r    <= ycnt_r + 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_index_r;
  assign out_row_bits  = out_row_bits_r;
  assign out_last_row  = out_last_row_r;

  `REMG_ASSERT_NEXT(a_last_row_ends_mask, emit_load && row_last, state_r == ST_IDLE, "mask did not end after its last row")
  `REMG_ASSERT_IMP(a_walk_within_row, state_r == ST_WALK, xcnt_r <= two_axis, "pixel counter ran past the row")
  `REMG_ASSERT_IMP(a_walk_lhs_nonneg, state_r == ST_WALK, lhs_r >= 0, "quadratic form went negative")
  `REMG_ASSERT_NEXT(a_empty_rows_clear, emit_load && empty_r, out_row_bits == '0, "zero-radius mask has set pixels")

endmodule

`default_nettype wire

FILE: dv/rotated_ellipse_mask_checker.sv
// Checker for the rotated ellipse mask generator: predicts every mask row and compares results.
module rotated_ellipse_mask_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [remg_pkg::RADIUS_W-1:0]        in_x_radius,
  input  logic [remg_pkg::RADIUS_W-1:0]        in_y_radius,
  input  logic [remg_pkg::DEG_W-1:0]           in_rotation_deg,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [remg_pkg::INDEX_W-1:0]         out_row_index,
  input  logic [remg_pkg::ROW_BITS_W-1:0]      out_row_bits,
  input  logic                                 out_last_row,
  output int                                   mismatches,
  output int                                   rows_pending,
  output int                                   rows_checked,
  output int                                   masks_requested,
  output int                                   empty_masks
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [remg_pkg::INDEX_W-1:0]    index;
    logic [remg_pkg::ROW_BITS_W-1:0] bits;
    logic                            last;
  } mask_row_t;

  // round(16384 * sin(k degrees)) for k = 0..90.
  localparam int SINE_QUARTER [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  mask_row_t expected_rows[$];

  initial begin
    mismatches      = 0;
    rows_pending    = 0;
    rows_checked    = 0;
    masks_requested = 0;
    empty_masks     = 0;
  end

  // Q1.14 sine of a whole-degree angle in 0..359, folded onto the quarter table.
  function automatic longint sine_of_deg(input int d);
    if (d <= 90) return SINE_QUARTER[d];
    if (d <= 180) return SINE_QUARTER[180 - d];
    if (d <= 270) return -SINE_QUARTER[d - 180];
    return -SINE_QUARTER[360 - d];
  endfunction

  function automatic void predict_mask_rows(input int rx, input int ry, input int deg);
    int        axis;
    int        angle;
    int        row_num;
    longint    s;
    longint    c;
    longint    a2;
    longint    b2;
    longint    bound;
    longint    n1;
    longint    n2;
    mask_row_t row;
    angle = (deg >= 360) ? deg - 360 : deg;
    axis  = (rx > ry) ? rx : ry;
    // The ellipse is turned by minus the angle: sin(-t) = -sin(t).
    s     = -sine_of_deg(angle);
    c     = sine_of_deg((angle + 90) % 360);
    a2    = rx * rx;
    b2    = ry * ry;
    bound = (a2 * b2) <<< 28;
    for (int y = -axis; y <= axis; y++) begin
      row.bits = '0;
      if (rx != 0 && ry != 0) begin
        for (int x = -axis; x <= axis; x++) begin
          n1 = x * c + y * s;
          n2 = x * s - y * c;
          if (n1 * n1 * b2 + n2 * n2 * a2 <= bound) row.bits[x + axis] = 1'b1;
        end
      end
      row_num   = y + axis;
      row.index = row_num[remg_pkg::INDEX_W-1:0];
      row.last  = (y == axis);
      expected_rows.push_back(row);
    end
  endfunction

  always @(posedge clk) begin
    mask_row_t want;
    if (rst_n) begin
      // Results are handled before a new request: a request never answers in the same cycle.
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected row: index %0d bits %h last %0b",
                     out_row_index, out_row_bits, out_last_row);
          end
        end else begin
          want = expected_rows.pop_front();
          rows_checked++;
          if (out_row_index !== want.index || out_row_bits !== want.bits ||
              out_last_row !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("row mismatch: expected index %0d bits %h last %0b",
                       want.index, want.bits, want.last);
              $display("              got      index %0d bits %h last %0b",
                       out_row_index, out_row_bits, out_last_row);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_mask_rows(int'(in_x_radius), int'(in_y_radius), int'(in_rotation_deg));
        masks_requested++;
        if (in_x_radius == 0 || in_y_radius == 0) empty_masks++;
      end
    end
    rows_pending = expected_rows.size();
  end

endmodule

FILE: dv/rotated_ellipse_mask_generator_tb.sv
// Testbench top for the rotated ellipse mask generator: stimulus, flow control and verdict.
module rotated_ellipse_mask_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 3000;
  localparam int RANDOM_COUNT = 117;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [remg_pkg::RADIUS_W-1:0]   in_x_radius = '0;
  logic [remg_pkg::RADIUS_W-1:0]   in_y_radius = '0;
  logic [remg_pkg::DEG_W-1:0]      in_rotation_deg = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [remg_pkg::INDEX_W-1:0]    out_row_index;
  logic [remg_pkg::ROW_BITS_W-1:0] out_row_bits;
  logic                            out_last_row;

  int mismatches;
  int rows_pending;
  int rows_checked;
  int masks_requested;
  int empty_masks;

  int send_idle_pct = 15;
  int recv_idle_pct = 76;
  int requests_sent = 0;
  bit hold_off      = 1'b0;

  rotated_ellipse_mask_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_radius     (in_x_radius),
    .in_y_radius     (in_y_radius),
    .in_rotation_deg (in_rotation_deg),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_row_bits    (out_row_bits),
    .out_last_row    (out_last_row)
  );

  rotated_ellipse_mask_checker mask_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_radius     (in_x_radius),
    .in_y_radius     (in_y_radius),
    .in_rotation_deg (in_rotation_deg),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_row_bits    (out_row_bits),
    .out_last_row    (out_last_row),
    .mismatches      (mismatches),
    .rows_pending    (rows_pending),
    .rows_checked    (rows_checked),
    .masks_requested (masks_requested),
    .empty_masks     (empty_masks)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Once the run is under way, the output is held off long enough for the block to back up.
  initial begin
    wait (requests_sent == 30);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("FAIL rotated_ellipse_mask_generator");
    $finish;
  end

  // Offers one request from the next falling edge and returns at the edge that takes it.
  task automatic offer_request(input int rx, input int ry, input int deg);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_x_radius     <= rx[remg_pkg::RADIUS_W-1:0];
    in_y_radius     <= ry[remg_pkg::RADIUS_W-1:0];
    in_rotation_deg <= deg[remg_pkg::DEG_W-1:0];
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  function automatic int pick_radius();
    if ($urandom_range(99) < 85) return $urandom_range(12);
    return $urandom_range(31);
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corners: both or one radius zero, largest radii, thin shapes, every quadrant,
    // and angles of 360 and above that wrap around.
    offer_request(0, 0, 0);
    offer_request(0, 9, 45);
    offer_request(12, 0, 200);
    offer_request(31, 31, 0);
    offer_request(31, 1, 45);
    offer_request(1, 31, 359);
    offer_request(31, 0, 511);
    offer_request(1, 1, 0);
    offer_request(5, 2, 0);
    offer_request(5, 2, 90);
    offer_request(5, 2, 180);
    offer_request(5, 2, 270);
    offer_request(5, 2, 360);
    offer_request(5, 2, 450);
    offer_request(7, 3, 30);
    offer_request(7, 3, 135);
    offer_request(7, 3, 225);
    offer_request(7, 3, 315);
    offer_request(20, 31, 89);
    offer_request(31, 20, 91);
    offer_request(16, 5, 271);
    offer_request(1, 2, 1);
    offer_request(31, 31, 511);

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == RANDOM_COUNT / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 15;
      end else if (i == 2 * RANDOM_COUNT / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      offer_request(pick_radius(), pick_radius(),
                    ($urandom_range(99) < 75) ? $urandom_range(359) : $urandom_range(511));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (rows_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d ellipse masks (%0d with a zero radius), %0d rows checked.",
             masks_requested, empty_masks, rows_checked);
    $display("Flow control: skewed idling both ways, no idling, and one long output hold-off.");
    if (mismatches == 0 && rows_pending == 0) begin
      $display("PASS rotated_ellipse_mask_generator");
    end else begin
      $display("%0d mismatches, %0d rows never arrived", mismatches, rows_pending);
      $display("FAIL rotated_ellipse_mask_generator");
    end
    $finish;
  end

endmodule
